/* rtl/bft_pkg.sv */
package bft_pkg;

	localparam int DEF_GLYPH_COUNT  = 256;
	localparam int DEF_MAX_TEXT_LEN = 256;

	localparam int GLYPH_BITS = 64;

	localparam logic [15:0] SAMPLE_THRESHOLD = 16'h8000;
	localparam logic [31:0] INK_COLOR        = 32'hFF00_0000;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_RENDER = 1'b1
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_FETCH,
		ST_WALK
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic ld_write;
		logic rd_load;
		logic step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sh_empty;
		logic sh_top;
		logic out_free;
	} dp_stat_t;

endpackage

/* rtl/bft_cmd_if.sv */
interface bft_cmd_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic        [7:0]  char_code;
	logic        [2:0]  glyph_row;
	logic        [2:0]  glyph_col;
	logic        [15:0] sample;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	logic        [7:0]  text_pos;

	modport source (
		output valid, command, char_code, glyph_row, glyph_col, sample,
		       origin_x, origin_y, text_pos,
		input  ready
	);
	modport sink (
		input  valid, command, char_code, glyph_row, glyph_col, sample,
		       origin_x, origin_y, text_pos,
		output ready
	);
endinterface

/* rtl/bft_pix_if.sv */
interface bft_pix_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pixel_x;
	logic signed [16:0] pixel_y;
	logic        [31:0] color;
	logic               last;

	modport source (
		output valid, pixel_x, pixel_y, color, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, color, last,
		output ready
	);
endinterface

/* rtl/bft_ctrl.sv */
module bft_ctrl
	import bft_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_command,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (in_command == CMD_RENDER) ? ST_FETCH : ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.ld_write = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_FETCH: begin
				cmd.rd_load = 1'b1;
				state_d     = ST_WALK;
			end
			ST_WALK: begin
				// blank pixels are skipped freely, set ones wait for the output slot
				if (stat.sh_empty) begin
					state_d = ST_IDLE;
				end else begin
					cmd.step = !stat.sh_top || stat.out_free;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/bft_dp.sv */
module bft_dp
	import bft_pkg::*;
#(
	parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT,
	parameter int MAX_TEXT_LEN = DEF_MAX_TEXT_LEN
) (
	input  logic           clk,
	input  logic           arst_n,
	bft_cmd_if.sink        cin,
	bft_pix_if.source      pix,
	input  dp_cmd_t        cmd,
	output dp_stat_t       stat
);

	localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam logic [8:0]  CODE_LIMIT = 9'(GLYPH_COUNT);
	localparam logic [12:0] POS_LIMIT  = 13'(MAX_TEXT_LEN);

	logic [GLYPH_BITS-1:0] mem [GLYPH_COUNT];
	logic [GLYPH_COUNT-1:0] vld_q;

	logic [AW-1:0]          addr_q;
	logic [5:0]             bit_q;
	logic                   set_q;
	logic                   in_range_q;
	logic [16:0]            base_x_q;
	logic [16:0]            oy_q;
	logic [GLYPH_BITS-1:0]  rdata_q;
	logic                   rvld_q;
	logic [GLYPH_BITS-1:0]  sh_q;
	logic [5:0]             idx_q;

	logic                   out_valid_q;
	logic [16:0]            out_x_q;
	logic [16:0]            out_y_q;
	logic                   out_last_q;

	logic                   code_ok;
	logic                   pos_ok;
	logic [GLYPH_BITS-1:0]  old_word;
	logic [GLYPH_BITS-1:0]  bit_mask;
	logic [GLYPH_BITS-1:0]  new_word;
	logic                   emit;

	assign code_ok = {1'b0, cin.char_code} < CODE_LIMIT;
	assign pos_ok  = {5'b0, cin.text_pos} < POS_LIMIT;

	// unwritten entries read as zero
	assign old_word = rvld_q ? rdata_q : '0;
	assign bit_mask = {{(GLYPH_BITS-1){1'b0}}, 1'b1} << bit_q;
	assign new_word = set_q ? (old_word | bit_mask) : (old_word & ~bit_mask);

	assign emit = cmd.step && sh_q[GLYPH_BITS-1];

	assign stat.sh_empty = (sh_q == '0);
	assign stat.sh_top   = sh_q[GLYPH_BITS-1];
	assign stat.out_free = !out_valid_q || pix.ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rdata_q <= mem[cin.char_code[AW-1:0]];
		end
		if (cmd.ld_write && in_range_q) begin
			mem[addr_q] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.ld_write && in_range_q) begin
			vld_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q     <= cin.char_code[AW-1:0];
			rvld_q     <= vld_q[cin.char_code[AW-1:0]];
			// bit 63 is top-left: index = 63 - (8*row + col)
			bit_q      <= ~{cin.glyph_row, cin.glyph_col};
			set_q      <= cin.sample < SAMPLE_THRESHOLD;
			in_range_q <= code_ok && (cin.command == CMD_LOAD || pos_ok);
			base_x_q   <= {cin.origin_x[15], cin.origin_x} + {6'b0, cin.text_pos, 3'b0};
			oy_q       <= {cin.origin_y[15], cin.origin_y};
		end
		if (cmd.rd_load) begin
			sh_q  <= in_range_q ? old_word : '0;
			idx_q <= '0;
		end else if (cmd.step) begin
			sh_q  <= {sh_q[GLYPH_BITS-2:0], 1'b0};
			idx_q <= idx_q + 6'd1;
		end
		if (emit) begin
			out_x_q    <= base_x_q + {14'b0, idx_q[2:0]};
			out_y_q    <= oy_q + {14'b0, idx_q[5:3]};
			out_last_q <= (sh_q[GLYPH_BITS-2:0] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pix.valid   = out_valid_q;
	assign pix.pixel_x = out_x_q;
	assign pix.pixel_y = out_y_q;
	assign pix.color   = INK_COLOR;
	assign pix.last    = out_last_q;

endmodule

/* rtl/bitmap_font_text_renderer_top.sv */
// 8x8 bitmap-font character generator. A load transaction (command 0) sets or
// clears one pixel of one stored glyph by a read-modify-write of the
// single-port glyph RAM (capture, then write). A render transaction (command 1)
// fetches the glyph, then scans it one pixel per cycle from the top-left corner
// (blank pixels never wait, set ones wait while the output holds an untaken pixel),
// stops after the last set pixel and returns to idle. One pixel transaction per
// set glyph pixel, the final one flagged by last; an empty glyph, a char_code
// at or beyond GLYPH_COUNT or a text_pos at or beyond MAX_TEXT_LEN renders
// nothing. No clipping is done. The glyph store reads as all zeros after reset
// with no clearing pass.
module bitmap_font_text_renderer_top
	import bft_pkg::*;
#(
	parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT,
	parameter int MAX_TEXT_LEN = DEF_MAX_TEXT_LEN
) (
	input  logic      clk,
	input  logic      arst_n,
	bft_cmd_if.sink   cmd,
	bft_pix_if.source pix
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	bft_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd.valid),
		.in_command (cmd.command),
		.in_ready   (cmd.ready),
		.stat       (dp_stat),
		.cmd        (dp_cmd)
	);

	bft_dp #(
		.GLYPH_COUNT  (GLYPH_COUNT),
		.MAX_TEXT_LEN (MAX_TEXT_LEN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cin    (cmd),
		.pix    (pix),
		.cmd    (dp_cmd),
		.stat   (dp_stat)
	);

	// a load never produces a pixel
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.command == CMD_LOAD && !pix.valid) |=> !pix.valid)
		else $error("pixel emitted after a load");

	// pixels only come out of the glyph scan, never while idle
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix.valid) |-> $past(!cmd.ready))
		else $error("pixel emitted while idle");

	// no two transactions are accepted back to back
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("input accepted back to back");

endmodule

/* bench/tb_bitmap_font_text_renderer_top.sv */
`timescale 1ns / 100ps

module tb_bitmap_font_text_renderer_top;
	import bft_pkg::*;

	localparam int RANDOM_ITEMS = 460;
	localparam int DRAIN_CYCLES = 80;    // fetch plus a full 64-pixel scan, with margin
	localparam int SINK_HOLD    = 400;
	localparam int POOL_SIZE    = 6;
	localparam logic [7:0] DENSE_CHAR = 8'hAA;

	typedef struct packed {
		cmd_code_t          command;
		logic        [7:0]  char_code;
		logic        [2:0]  glyph_row;
		logic        [2:0]  glyph_col;
		logic        [15:0] sample;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic        [7:0]  text_pos;
	} font_cmd_t;

	typedef struct packed {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic        [31:0] color;
		logic               last;
	} ink_px_t;

	typedef struct packed {
		font_cmd_t          item;
		bit                 golden;     // expected pixels typed in below, not predicted
		int                 golden_n;   // 0 or 1 pixel
		logic signed [16:0] gx;
		logic signed [16:0] gy;
	} dir_row_t;

	logic clk;
	logic arst_n;

	bft_cmd_if cmd ();
	bft_pix_if pix ();

	bitmap_font_text_renderer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pix    (pix)
	);

	bit [63:0] glyph_mem [DEF_GLYPH_COUNT];
	ink_px_t   pixel_q [$];
	dir_row_t  dir_tab [$];

	int  fails;
	int  n_loads;
	int  n_renders;
	int  n_pixels;
	int  hold_req;
	int  longest_hold;
	bit  idle_on;

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("watchdog expired with %0d pixels still expected", pixel_q.size());
		$display("status: fail");
		$finish;
	end

	function automatic int pick_gap();
		if (!idle_on || $urandom_range(0, 99) < 60)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic font_cmd_t random_cmd();
		font_cmd_t it;
		it.command   = cmd_code_t'($urandom_range(0, 1));
		it.char_code = 8'($urandom_range(0, 255));
		it.glyph_row = 3'($urandom_range(0, 7));
		it.glyph_col = 3'($urandom_range(0, 7));
		it.sample    = 16'($urandom_range(0, 16'hFFFF));
		it.origin_x  = 16'($urandom_range(0, 16'hFFFF));
		it.origin_y  = 16'($urandom_range(0, 16'hFFFF));
		it.text_pos  = 8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic note_fail(input string msg);
		fails++;
		if (fails <= 10)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// Loads update the glyph copy; renders scan it and queue one pixel per set bit.
	task automatic trace_glyph(input font_cmd_t it);
		int      px;
		int      bit_idx;
		ink_px_t p;
		ink_px_t run [$];
		if (it.command == CMD_LOAD) begin
			if (it.char_code < DEF_GLYPH_COUNT) begin
				bit_idx = 63 - (8 * it.glyph_row + it.glyph_col);
				glyph_mem[it.char_code][bit_idx] = (it.sample < SAMPLE_THRESHOLD);
			end
			return;
		end
		// char/pos bounds can't trip at default sizes, kept for other parameterizations
		if (it.char_code >= DEF_GLYPH_COUNT || it.text_pos >= DEF_MAX_TEXT_LEN)
			return;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				if (glyph_mem[it.char_code][63 - (8 * r + c)]) begin
					px      = int'(it.origin_x) + c + 8 * int'(it.text_pos);
					p.x     = px[16:0];
					px      = int'(it.origin_y) + r;
					p.y     = px[16:0];
					p.color = INK_COLOR;
					p.last  = 1'b0;
					run.push_back(p);
				end
			end
		end
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			pixel_q.push_back(run[i]);
	endtask

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic offer(input font_cmd_t it, input int gap, input bit use_model);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.command   <= it.command;
		cmd.char_code <= it.char_code;
		cmd.glyph_row <= it.glyph_row;
		cmd.glyph_col <= it.glyph_col;
		cmd.sample    <= it.sample;
		cmd.origin_x  <= it.origin_x;
		cmd.origin_y  <= it.origin_y;
		cmd.text_pos  <= it.text_pos;
		do
			@(posedge clk);
		while (!cmd.ready);
		if (it.command == CMD_LOAD)
			n_loads++;
		else
			n_renders++;
		if (use_model)
			trace_glyph(it);
	endtask

	task automatic wait_drained();
		while (pixel_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_pixel();
		ink_px_t want;
		n_pixels++;
		if (pixel_q.size() == 0) begin
			note_fail($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
				pix.pixel_x, pix.pixel_y, pix.color, pix.last));
			return;
		end
		want = pixel_q.pop_front();
		if (pix.pixel_x !== want.x || pix.pixel_y !== want.y ||
		    pix.color !== want.color || pix.last !== want.last)
			note_fail($sformatf(
				"exp x=%0d y=%0d color=%h last=%b, got x=%0d y=%0d color=%h last=%b",
				want.x, want.y, want.color, want.last,
				pix.pixel_x, pix.pixel_y, pix.color, pix.last));
	endtask

	task automatic tab(input cmd_code_t op, input logic [7:0] code, input logic [2:0] r,
		input logic [2:0] c, input logic [15:0] s, input logic signed [15:0] ox,
		input logic signed [15:0] oy, input logic [7:0] pos, input bit g, input int gn,
		input logic signed [16:0] gx, input logic signed [16:0] gy);
		dir_row_t row;
		row.item     = '{op, code, r, c, s, ox, oy, pos};
		row.golden   = g;
		row.golden_n = gn;
		row.gx       = gx;
		row.gy       = gy;
		dir_tab.push_back(row);
	endtask

	// pixel sink: checks every transaction, drives ready with random stalls
	initial begin : pixel_sink
		int stall_left;
		stall_left = 0;
		pix.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (pix.valid && pix.ready)
				check_pixel();
			if (hold_req > 0) begin
				stall_left   = hold_req;
				longest_hold = hold_req;
				hold_req     = 0;
			end
			if (stall_left > 0) begin
				pix.ready <= 1'b0;
				stall_left--;
			end else begin
				pix.ready <= 1'b1;
				stall_left = pick_gap();
			end
			@(posedge clk);
		end
	end

	initial begin : stimulus
		font_cmd_t  it;
		ink_px_t    p;
		logic [7:0] pool [POOL_SIZE];
		logic [7:0] code;
		int         sent;
		int         dens;
		int         n;
		int         start;
		int         k;

		arst_n        = 1'b0;
		cmd.valid     <= 1'b0;
		cmd.command   <= CMD_LOAD;
		cmd.char_code <= '0;
		cmd.glyph_row <= '0;
		cmd.glyph_col <= '0;
		cmd.sample    <= '0;
		cmd.origin_x  <= '0;
		cmd.origin_y  <= '0;
		cmd.text_pos  <= '0;
		idle_on       = 1'b1;

		// op, char, row, col, sample, ox, oy, pos, golden, n, x, y
		tab(CMD_RENDER, 8'd0,   0, 0, 16'h0000, 0,      0,      0,   1, 0, 0, 0);
		tab(CMD_RENDER, 8'd255, 0, 0, 16'h0000, -32768, 32767,  255, 1, 0, 0, 0);
		tab(CMD_LOAD,   8'd1,   0, 0, 16'h0000, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_RENDER, 8'd1,   0, 0, 16'h0000, -32768, -32768, 0,   1, 1, -32768, -32768);
		tab(CMD_RENDER, 8'd1,   0, 0, 16'h0000, 32767,  32767,  255, 1, 1, 34807, 32767);
		// sample exactly at threshold clears the pixel
		tab(CMD_LOAD,   8'd1,   0, 0, 16'h8000, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_RENDER, 8'd1,   0, 0, 16'h0000, 0,      0,      0,   1, 0, 0, 0);
		tab(CMD_LOAD,   8'd1,   7, 7, 16'h7FFF, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_RENDER, 8'd1,   0, 0, 16'h0000, 32767,  32767,  255, 1, 1, 34814, 32774);
		tab(CMD_RENDER, 8'd1,   0, 0, 16'h0000, -32768, -32768, 0,   1, 1, -32761, -32761);
		tab(CMD_LOAD,   8'd1,   7, 7, 16'hFFFF, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_LOAD,   8'd0,   0, 7, 16'h0001, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_LOAD,   8'd0,   7, 0, 16'h0000, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_LOAD,   8'd0,   3, 4, 16'h7FFF, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_LOAD,   8'd255, 4, 3, 16'h1234, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_LOAD,   8'd255, 5, 2, 16'h9000, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_RENDER, 8'd0,   0, 0, 16'h0000, -1,     -1,     1,   0, 0, 0, 0);
		tab(CMD_RENDER, 8'd255, 0, 0, 16'h0000, 1000,   -1000,  128, 0, 0, 0, 0);
		tab(CMD_RENDER, 8'd1,   0, 0, 16'h0000, 5,      5,      5,   1, 0, 0, 0);
		tab(CMD_LOAD,   8'd128, 2, 5, 16'h7FFF, 0,      0,      0,   0, 0, 0, 0);
		tab(CMD_RENDER, 8'd128, 0, 0, 16'h0000, -32768, 32767,  255, 1, 1, -30723, 32769);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			offer(dir_tab[i].item, pick_gap(), !dir_tab[i].golden);
			if (dir_tab[i].golden && dir_tab[i].golden_n == 1) begin
				p.x     = dir_tab[i].gx;
				p.y     = dir_tab[i].gy;
				p.color = INK_COLOR;
				p.last  = 1'b1;
				pixel_q.push_back(p);
			end
		end

		// fully inked glyph: 64 pixels per render
		for (int i = 0; i < 64; i++) begin
			it           = random_cmd();
			it.command   = CMD_LOAD;
			it.char_code = DENSE_CHAR;
			it.glyph_row = 3'(i / 8);
			it.glyph_col = 3'(i % 8);
			it.sample    = 16'($urandom_range(0, 16'h7FFF));
			offer(it, pick_gap(), 1'b1);
		end
		sent = dir_tab.size() + 64;

		// sink holds off while renders keep coming, so the input backs up
		wait_drained();
		hold_req = SINK_HOLD;
		repeat (8) begin
			it           = random_cmd();
			it.command   = CMD_RENDER;
			it.char_code = DENSE_CHAR;
			offer(it, 0, 1'b1);
			sent++;
		end
		cmd.valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		foreach (pool[i])
			pool[i] = 8'($urandom_range(0, 255));
		pool[0] = DENSE_CHAR;

		while (sent < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) < 7) begin
				// paint a run of pixels into a pooled glyph, then render some of the pool
				code  = pool[$urandom_range(1, POOL_SIZE - 1)];
				dens  = $urandom_range(0, 100);
				n     = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
				start = $urandom_range(0, 63);
				for (int j = 0; j < n; j++) begin
					k            = (start + j) % 64;
					it           = random_cmd();
					it.command   = CMD_LOAD;
					it.char_code = code;
					it.glyph_row = 3'(k / 8);
					it.glyph_col = 3'(k % 8);
					it.sample    = ($urandom_range(0, 99) < dens) ?
						16'($urandom_range(0, 16'h7FFF)) :
						16'($urandom_range(16'h8000, 16'hFFFF));
					offer(it, pick_gap(), 1'b1);
					sent++;
				end
				repeat ($urandom_range(1, 3)) begin
					it           = random_cmd();
					it.command   = CMD_RENDER;
					it.char_code = pool[$urandom_range(0, POOL_SIZE - 1)];
					offer(it, pick_gap(), 1'b1);
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					offer(random_cmd(), pick_gap(), 1'b1);
					sent++;
				end
			end
			if ($urandom_range(0, 15) == 0) begin
				cmd.valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
		end

		cmd.valid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d glyph loads, %0d renders, %0d pixels checked, %0d mismatches",
			n_loads, n_renders, n_pixels, fails);
		$display("run: coordinate extremes, threshold edge, dense glyphs, %0d-cycle sink hold",
			longest_hold);
		if (fails == 0 && pixel_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
